>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define RSH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radial histogram check failed");

// Next-cycle implication, checked on clk, off during reset.
`define RSH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radial histogram check failed");

`endif

>>> hdl/rsh_pkg.sv
`default_nettype none

package rsh_pkg;

	// Field widths
	localparam int CFG_W   = 9;
	localparam int SUM_W   = 48;
	localparam int WSUM_W  = 56;
	localparam int CNT_W   = 25;
	localparam int PWR_W   = 32;
	localparam int HALF_W  = 24;

	localparam int DEF_MAX_SIDE = 256;
	localparam logic [CFG_W-1:0] SIDE_RST = 9'd256;

	localparam logic [63:0] WSUM_MAX = (64'd1 << WSUM_W) - 64'd1;

	// Actions
	localparam logic [1:0] ACT_ACCUM = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Result status
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_COORD = 2'd1;
	localparam logic [1:0] STS_BIN   = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_SIDE_X = 2'd0;
	localparam logic [1:0] REG_SIDE_Y = 2'd1;
	localparam logic [1:0] REG_SIDE_Z = 2'd2;

endpackage

`default_nettype wire

>>> hdl/radial_spectrum_histogram.sv
// Accumulate runs the root and divide steps from accept to result (RW = 36 root bits and
// LW = 9 quotient bits at MAX_SIDE 256, one bit a cycle); read, clear and rejected skip them.
// One transaction at a time: the next accept comes in the cycle after the result issues,
// and a stalled result holds off the next accept until it issues.
// Reset clears the control state and the side registers to 256, then a clearing
// pass zeroes all MAX_SIDE entries of the bin memory; no input is taken meanwhile.
`default_nettype none

`include "assert_macros.svh"

module radial_spectrum_histogram #(
	parameter int MAX_SIDE = rsh_pkg::DEF_MAX_SIDE
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [rsh_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   action,
	input  wire logic [7:0]                   coord_x,
	input  wire logic [7:0]                   coord_y,
	input  wire logic [7:0]                   coord_z,
	input  wire logic [rsh_pkg::PWR_W-1:0]    power_value,
	input  wire logic [7:0]                   bin_select,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [7:0]                        bin_number,
	output logic [rsh_pkg::SUM_W-1:0]         bin_sum,
	output logic [rsh_pkg::WSUM_W-1:0]        weighted_sum,
	output logic [rsh_pkg::CNT_W-1:0]         bin_count
);

	localparam int LW   = $clog2(MAX_SIDE + 1);
	localparam int BW   = $clog2(MAX_SIDE);
	localparam int XW   = (LW > 8) ? LW : 8;
	localparam int L2W  = 2 * LW;
	localparam int AW   = 8 + L2W;
	localparam int PW   = 3 * LW;
	localparam int NW   = 2 * AW + 2;
	localparam int NPAD = 2 * ((NW + 1) / 2);
	localparam int NH   = NPAD / 2;
	localparam int MW   = 2 * ((NW + L2W + 1) / 2);
	localparam int RW   = MW / 2;
	localparam int ITW  = $clog2(RW);
	localparam int DW   = RW + LW;
	localparam int EW   = rsh_pkg::SUM_W + rsh_pkg::CNT_W;
	localparam int HW   = rsh_pkg::HALF_W;

	typedef enum logic [15:0] {
		ST_CLEAR = 16'h0001,
		ST_IDLE  = 16'h0002,
		ST_DISP  = 16'h0004,
		ST_TERMS = 16'h0008,
		ST_SQA   = 16'h0010,
		ST_SQB   = 16'h0020,
		ST_SQC   = 16'h0040,
		ST_MLO   = 16'h0080,
		ST_MHI   = 16'h0100,
		ST_ROOT  = 16'h0200,
		ST_DIV   = 16'h0400,
		ST_READ  = 16'h0800,
		ST_MOD   = 16'h1000,
		ST_WLO   = 16'h2000,
		ST_WHI   = 16'h4000,
		ST_EMIT  = 16'h8000
	} state_t;

	function automatic logic [LW-1:0] eff_side(input logic [rsh_pkg::CFG_W-1:0] s);
		if (int'(s) < 2) return LW'(2);
		if (int'(s) > MAX_SIDE) return LW'(MAX_SIDE);
		return LW'(s);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c, input logic [LW-1:0] l);
		if (XW'(c) > XW'(l >> 1)) return 8'(XW'(l) - XW'(c));
		return c;
	endfunction

	state_t state_q;

	logic [rsh_pkg::CFG_W-1:0] side_x_q, side_y_q, side_z_q;
	logic [BW-1:0]  clr_cnt_q;
	logic [1:0]     act_q;
	logic [7:0]     cx_q, cy_q, cz_q, sel_q;
	logic [rsh_pkg::PWR_W-1:0] pw_q;
	logic [7:0]     tx_q, ty_q, tz_q;
	logic [L2W-1:0] lylz_q, lxlz_q, lxly_q, nb2_q;
	logic [AW-1:0]  a_q, b_q, c_q;
	logic [PW-1:0]  p_q;
	logic [NW-1:0]  n_q;
	logic [NH+L2W-1:0] mlo_q;
	logic [MW-1:0]  m_q;
	logic [RW+1:0]  rem_q;
	logic [RW-1:0]  root_q;
	logic [RW-1:0]  dv_q;
	logic [LW-1:0]  quo_q;
	logic [ITW-1:0] it_q;
	logic [BW-1:0]  idx_q;
	logic [7:0]     bin_q;
	logic [1:0]     sts_q;
	logic [rsh_pkg::SUM_W-1:0] sum_q;
	logic [rsh_pkg::CNT_W-1:0] cnt_q;
	logic [HW+LW-1:0] wlo_q;
	logic [63:0]    wsum_q;

	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [7:0]     bin_number_q;
	logic [rsh_pkg::SUM_W-1:0]  bin_sum_q;
	logic [rsh_pkg::WSUM_W-1:0] weighted_sum_q;
	logic [rsh_pkg::CNT_W-1:0]  bin_count_q;

	logic [EW-1:0]  mem [MAX_SIDE];
	logic [EW-1:0]  rdata_q;
	logic           mem_we;
	logic [BW-1:0]  mem_waddr;
	logic [EW-1:0]  mem_wdata;

	// Effective sides and bin count
	logic [LW-1:0]  lx, ly, lz, nb;
	logic           coord_bad, sel_bad, out_free, in_acc;

	always_comb begin
		lx = eff_side(side_x_q);
		ly = eff_side(side_y_q);
		lz = eff_side(side_z_q);
		nb = lx;
		if (ly < nb) nb = ly;
		if (lz < nb) nb = lz;
	end

	assign coord_bad = (XW'(cx_q) >= XW'(lx)) || (XW'(cy_q) >= XW'(ly))
		|| (XW'(cz_q) >= XW'(lz));
	assign sel_bad   = (XW'(sel_q) >= XW'(nb)) || (XW'(sel_q) >= XW'(MAX_SIDE));
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Root step
	logic [RW+1:0] rem_sh, rtrial;
	logic          rbit;
	logic [RW-1:0] root_nx;

	always_comb begin
		rem_sh  = {rem_q[RW-1:0], m_q[MW-1 -: 2]};
		rtrial  = {root_q, 2'b01};
		rbit    = (rem_sh >= rtrial);
		root_nx = {root_q[RW-2:0], rbit};
	end

	// Divide step and bin clamp
	logic [DW-1:0] dtrial;
	logic          dbit;
	logic [LW-1:0] quo_nx, bin_fin;

	always_comb begin
		dtrial  = DW'(p_q) << it_q;
		dbit    = (DW'(dv_q) >= dtrial);
		quo_nx  = {quo_q[LW-2:0], dbit};
		bin_fin = (quo_nx >= nb) ? (nb - LW'(1)) : quo_nx;
	end

	// Bin update
	logic [rsh_pkg::SUM_W-1:0] rd_sum, new_sum;
	logic [rsh_pkg::CNT_W-1:0] rd_cnt, new_cnt;
	logic [rsh_pkg::SUM_W:0]   sum_ext;
	logic [LW-1:0]             kmul;

	always_comb begin
		rd_sum  = rdata_q[EW-1 -: rsh_pkg::SUM_W];
		rd_cnt  = rdata_q[rsh_pkg::CNT_W-1:0];
		sum_ext = {1'b0, rd_sum} + (rsh_pkg::SUM_W + 1)'(pw_q);
		new_sum = sum_ext[rsh_pkg::SUM_W] ? '1 : sum_ext[rsh_pkg::SUM_W-1:0];
		new_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
		kmul    = LW'(idx_q) + LW'(1);
	end

	// Memory write select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {new_sum, new_cnt};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == ST_MOD) begin
			if (act_q == rsh_pkg::ACT_ACCUM) begin
				mem_we = 1'b1;
			end else if (act_q == rsh_pkg::ACT_CLEAR) begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
		end
	end

	// Bin memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[idx_q];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_x_q <= rsh_pkg::SIDE_RST;
			side_y_q <= rsh_pkg::SIDE_RST;
			side_z_q <= rsh_pkg::SIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsh_pkg::REG_SIDE_X: side_x_q <= cfg_data;
				rsh_pkg::REG_SIDE_Y: side_y_q <= cfg_data;
				rsh_pkg::REG_SIDE_Z: side_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Result valid: set when issued, dropped when taken
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == BW'(MAX_SIDE - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_acc) state_q <= ST_DISP;
				ST_DISP: begin
					if (act_q == rsh_pkg::ACT_ACCUM) begin
						state_q <= coord_bad ? ST_WLO : ST_TERMS;
					end else begin
						state_q <= sel_bad ? ST_WLO : ST_READ;
					end
				end
				ST_TERMS: state_q <= ST_SQA;
				ST_SQA:   state_q <= ST_SQB;
				ST_SQB:   state_q <= ST_SQC;
				ST_SQC:   state_q <= ST_MLO;
				ST_MLO:   state_q <= ST_MHI;
				ST_MHI:   state_q <= ST_ROOT;
				ST_ROOT:  if (it_q == '0) state_q <= ST_DIV;
				ST_DIV:   if (it_q == '0) state_q <= ST_READ;
				ST_READ:  state_q <= ST_MOD;
				ST_MOD:   state_q <= ST_WLO;
				ST_WLO:   state_q <= ST_WHI;
				ST_WHI:   state_q <= ST_EMIT;
				ST_EMIT:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q <= action;
				cx_q  <= coord_x;
				cy_q  <= coord_y;
				cz_q  <= coord_z;
				pw_q  <= power_value;
				sel_q <= bin_select;
			end
			ST_DISP: begin
				tx_q   <= fold(cx_q, lx);
				ty_q   <= fold(cy_q, ly);
				tz_q   <= fold(cz_q, lz);
				lylz_q <= L2W'(ly) * L2W'(lz);
				lxlz_q <= L2W'(lx) * L2W'(lz);
				lxly_q <= L2W'(lx) * L2W'(ly);
				nb2_q  <= L2W'(nb) * L2W'(nb);
				sum_q  <= '0;
				cnt_q  <= '0;
				idx_q  <= BW'(sel_q);
				priority if (act_q == rsh_pkg::ACT_ACCUM && coord_bad) begin
					sts_q <= rsh_pkg::STS_COORD;
					bin_q <= '0;
				end else if (act_q != rsh_pkg::ACT_ACCUM && sel_bad) begin
					sts_q <= rsh_pkg::STS_BIN;
					bin_q <= sel_q;
				end else begin
					sts_q <= rsh_pkg::STS_OK;
					bin_q <= sel_q;
				end
			end
			ST_TERMS: begin
				a_q <= AW'(tx_q) * AW'(lylz_q);
				b_q <= AW'(ty_q) * AW'(lxlz_q);
				c_q <= AW'(tz_q) * AW'(lxly_q);
				p_q <= PW'(lx) * PW'(lylz_q);
			end
			ST_SQA: n_q <= NW'(a_q) * NW'(a_q);
			ST_SQB: n_q <= n_q + NW'(b_q) * NW'(b_q);
			ST_SQC: n_q <= n_q + NW'(c_q) * NW'(c_q);
			ST_MLO: mlo_q <= (NH + L2W)'(n_q[NH-1:0]) * (NH + L2W)'(nb2_q);
			ST_MHI: begin
				m_q <= (MW'((NH + L2W)'(NPAD'(n_q) >> NH) * (NH + L2W)'(nb2_q)) << NH)
					+ MW'(mlo_q);
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= ITW'(RW - 1);
			end
			// One root bit a cycle
			ST_ROOT: begin
				rem_q  <= rbit ? (rem_sh - rtrial) : rem_sh;
				root_q <= root_nx;
				m_q    <= m_q << 2;
				it_q   <= (it_q == '0) ? ITW'(LW - 1) : it_q - 1'b1;
				if (it_q == '0) begin
					dv_q  <= root_nx;
					quo_q <= '0;
				end
			end
			// One quotient bit a cycle
			ST_DIV: begin
				if (dbit) dv_q <= dv_q - RW'(dtrial);
				quo_q <= quo_nx;
				it_q  <= it_q - 1'b1;
				if (it_q == '0) begin
					idx_q <= BW'(bin_fin);
					bin_q <= 8'(bin_fin);
				end
			end
			ST_MOD: begin
				if (act_q == rsh_pkg::ACT_ACCUM) begin
					sum_q <= new_sum;
					cnt_q <= new_cnt;
				end else if (act_q == rsh_pkg::ACT_CLEAR) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= rd_sum;
					cnt_q <= rd_cnt;
				end
			end
			ST_WLO: wlo_q <= (HW + LW)'(sum_q[HW-1:0]) * (HW + LW)'(kmul);
			ST_WHI: begin
				wsum_q <= (64'((HW + LW)'(sum_q[rsh_pkg::SUM_W-1:HW]) * (HW + LW)'(kmul))
					<< HW) + 64'(wlo_q);
			end
			ST_EMIT: begin
				if (out_free) begin
					status_q       <= sts_q;
					bin_number_q   <= bin_q;
					bin_sum_q      <= sum_q;
					bin_count_q    <= cnt_q;
					weighted_sum_q <= (wsum_q > rsh_pkg::WSUM_MAX) ? '1
						: wsum_q[rsh_pkg::WSUM_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bin_number   = bin_number_q;
	assign bin_sum      = bin_sum_q;
	assign weighted_sum = weighted_sum_q;
	assign bin_count    = bin_count_q;

	// Checks
	`RSH_ASSERT_NXT(a_accept_disp, in_valid && in_ready, state_q == ST_DISP)
	`RSH_ASSERT_IMP(a_we_state, mem_we, state_q == ST_CLEAR || state_q == ST_MOD)
	`RSH_ASSERT_IMP(a_idx_range, state_q == ST_MOD, XW'(idx_q) < XW'(nb))
	`RSH_ASSERT_IMP(a_no_in_clear, state_q == ST_CLEAR, !in_ready && !out_valid)

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [1:0]                 status;
		logic [7:0]                 bin;
		logic [rsh_pkg::SUM_W-1:0]  sum;
		logic [rsh_pkg::WSUM_W-1:0] wsum;
		logic [rsh_pkg::CNT_W-1:0]  cnt;
	} bin_report_t;

	localparam logic [rsh_pkg::SUM_W-1:0] SUM_SAT = '1;
	localparam logic [rsh_pkg::CNT_W-1:0] CNT_SAT = '1;
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [rsh_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [1:0] action = '0;
	logic [7:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [rsh_pkg::PWR_W-1:0] power_value = '0;
	logic [7:0] bin_select = '0;
	logic out_ready = 1'b0;
	wire cfg_ready, in_ready, out_valid;
	wire [1:0] status;
	wire [7:0] bin_number;
	wire [rsh_pkg::SUM_W-1:0] bin_sum;
	wire [rsh_pkg::WSUM_W-1:0] weighted_sum;
	wire [rsh_pkg::CNT_W-1:0] bin_count;

	radial_spectrum_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.power_value(power_value), .bin_select(bin_select),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.bin_number(bin_number), .bin_sum(bin_sum), .weighted_sum(weighted_sum),
		.bin_count(bin_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the histogram and side registers
	logic [rsh_pkg::CFG_W-1:0] side_reg [3];
	logic [rsh_pkg::SUM_W-1:0] hist_sum [256];
	logic [rsh_pkg::CNT_W-1:0] hist_cnt [256];
	bin_report_t pending_reports [$];
	int errors = 0;
	bit no_idle = 1'b0;

	function automatic int unsigned clamp_side(logic [rsh_pkg::CFG_W-1:0] s);
		if (s < 2) return 2;
		if (s > 256) return 256;
		return s;
	endfunction

	function automatic int unsigned nbins();
		int unsigned lx, ly, lz, nb;
		lx = clamp_side(side_reg[0]);
		ly = clamp_side(side_reg[1]);
		lz = clamp_side(side_reg[2]);
		nb = lx;
		if (ly < nb) nb = ly;
		if (lz < nb) nb = lz;
		return nb;
	endfunction

	// Expected report per action; accumulate bins by exact integer search for floor(nb * |k|)
	function automatic bin_report_t bin_power(logic [1:0] act, logic [7:0] cx, logic [7:0] cy,
			logic [7:0] cz, logic [31:0] pw, logic [7:0] sel);
		int unsigned lx, ly, lz, nb, tx, ty, tz, b;
		logic [127:0] den, num;
		logic [48:0] s;
		logic [63:0] w;
		bin_report_t r;
		lx = clamp_side(side_reg[0]);
		ly = clamp_side(side_reg[1]);
		lz = clamp_side(side_reg[2]);
		nb = nbins();
		r = '0;
		b = 0;
		if (act == rsh_pkg::ACT_ACCUM) begin
			if (cx >= lx || cy >= ly || cz >= lz) begin
				r.status = rsh_pkg::STS_COORD;
				return r;
			end
			tx = (cx > lx / 2) ? lx - cx : cx;
			ty = (cy > ly / 2) ? ly - cy : cy;
			tz = (cz > lz / 2) ? lz - cz : cz;
			den = 128'(lx * lx) * 128'(ly * ly) * 128'(lz * lz);
			num = 128'(tx * tx) * 128'(ly * ly) * 128'(lz * lz)
				+ 128'(ty * ty) * 128'(lx * lx) * 128'(lz * lz)
				+ 128'(tz * tz) * 128'(lx * lx) * 128'(ly * ly);
			for (int k = 1; k < nb; k++)
				if (128'(k * k) * den <= 128'(nb * nb) * num) b = k;
			s = {1'b0, hist_sum[b]} + 49'(pw);
			hist_sum[b] = (s > 49'(SUM_SAT)) ? SUM_SAT : s[rsh_pkg::SUM_W-1:0];
			if (hist_cnt[b] != CNT_SAT) hist_cnt[b] = hist_cnt[b] + 1'b1;
		end else begin
			b = sel;
			if (sel >= nb) begin
				r.status = rsh_pkg::STS_BIN;
				r.bin = sel;
				return r;
			end
			if (act == rsh_pkg::ACT_CLEAR) begin
				hist_sum[b] = '0;
				hist_cnt[b] = '0;
			end
		end
		r.status = rsh_pkg::STS_OK;
		r.bin = b[7:0];
		r.sum = hist_sum[b];
		r.cnt = hist_cnt[b];
		w = 64'(hist_sum[b]) * 64'(b + 1);
		r.wsum = (w > rsh_pkg::WSUM_MAX) ? rsh_pkg::WSUM_MAX[rsh_pkg::WSUM_W-1:0]
			: w[rsh_pkg::WSUM_W-1:0];
		return r;
	endfunction

	// Send one transaction; returns at the edge where it is taken
	task automatic send_item(logic [1:0] act, logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
			logic [31:0] pw, logic [7:0] sel);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		power_value <= pw;
		bin_select <= sel;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_reports.push_back(bin_power(act, cx, cy, cz, pw, sel));
	endtask

	// Wait until every expected result has come back, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// One register write, then the write channel is left idle before returning
	task automatic write_reg(logic [1:0] idx, logic [rsh_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx != REG_SPARE) side_reg[idx] = val;
		@(posedge clk);
	endtask

	task automatic set_sides(logic [rsh_pkg::CFG_W-1:0] sx, logic [rsh_pkg::CFG_W-1:0] sy,
			logic [rsh_pkg::CFG_W-1:0] sz);
		drain_results();
		write_reg(rsh_pkg::REG_SIDE_X, sx);
		write_reg(rsh_pkg::REG_SIDE_Y, sy);
		write_reg(rsh_pkg::REG_SIDE_Z, sz);
	endtask

	// Result side: random stall after each transaction, none in the no-idle phase
	bit rx_took = 1'b0;
	int rx_wait = 0;
	always @(posedge clk) begin
		if (rx_took) begin
			rx_wait = no_idle ? 0 : $urandom_range(0, 9);
			rx_took = 1'b0;
		end
		if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// Compare each result transaction with the oldest expected report
	always @(negedge clk) begin
		bin_report_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			rx_took = 1'b1;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, status %0d bin %0d", $time, status, bin_number);
				errors++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status exp %0d got %0d", $time, exp_r.status, status);
					errors++;
				end
				if (bin_number !== exp_r.bin) begin
					$display("%0t: bin_number exp %0d got %0d", $time, exp_r.bin, bin_number);
					errors++;
				end
				if (bin_sum !== exp_r.sum) begin
					$display("%0t: bin_sum exp %0h got %0h", $time, exp_r.sum, bin_sum);
					errors++;
				end
				if (weighted_sum !== exp_r.wsum) begin
					$display("%0t: weighted_sum exp %0h got %0h", $time, exp_r.wsum,
						weighted_sum);
					errors++;
				end
				if (bin_count !== exp_r.cnt) begin
					$display("%0t: bin_count exp %0d got %0d", $time, exp_r.cnt, bin_count);
					errors++;
				end
			end
		end
	end

	// Full 256 grid: fold edges, extreme powers, every action
	task automatic test_directed_full_grid();
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0);
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd255);
		send_item(rsh_pkg::ACT_ACCUM, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd0, 8'd0, 8'd0, 32'd0, 8'hFF);
		send_item(rsh_pkg::ACT_ACCUM, 8'd128, 8'd128, 8'd128, 32'hFFFF_FFFF, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd129, 8'd0, 8'd0, 32'h0001_0000, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd255, 8'd255, 8'd255, 32'h8000_0001, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd128, 8'd0, 8'd0, 32'h1234_5678, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd90, 8'd91, 8'd92, 32'hFFFF_FFFF, 8'd0);
		send_item(rsh_pkg::ACT_READ, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'd128);
		send_item(ACT_SPARE, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0);
		send_item(rsh_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0);
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd0);
		send_item(rsh_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0, 32'd0, 8'd255);
	endtask

	// Small grids: coordinate beyond side, bin beyond count, clamped sides
	task automatic test_directed_small_grid();
		set_sides(9'd0, 9'd1, 9'd511);
		send_item(rsh_pkg::ACT_ACCUM, 8'd1, 8'd1, 8'd1, 32'hFFFF_FFFF, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd2, 8'd0, 8'd0, 32'd5, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd0, 8'd0, 8'd200, 32'd5, 8'd0);
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd1);
		send_item(rsh_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0, 32'd0, 8'd2);
		set_sides(9'd256, 9'd17, 9'd100);
		write_reg(REG_SPARE, 9'h0AA);
		send_item(rsh_pkg::ACT_ACCUM, 8'd16, 8'd8, 8'd99, 32'd7, 8'd0);
		send_item(rsh_pkg::ACT_ACCUM, 8'd255, 8'd17, 8'd0, 32'd7, 8'd0);
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd16);
		send_item(rsh_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 32'd0, 8'd17);
	endtask

	function automatic logic [7:0] pick_coord(int unsigned side);
		if ($urandom_range(0, 9) == 0) return 8'($urandom);
		return 8'($urandom_range(0, side - 1));
	endfunction

	// Random phases over changing grid shapes
	task automatic test_random_phases();
		int unsigned nb, pick;
		logic [1:0] act;
		logic [7:0] sel;
		logic [31:0] pw;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_sides(9'd256, 9'd256, 9'd256);
				1: set_sides(9'd2, 9'd2, 9'd2);
				default: begin
					set_sides(9'($urandom_range(0, 511)), 9'($urandom_range(2, 256)),
						9'($urandom_range(2, 256)));
				end
			endcase
			no_idle = (ph == 3);
			nb = nbins();
			for (int i = 0; i < 95; i++) begin
				pick = $urandom_range(0, 99);
				act = (pick < 60) ? rsh_pkg::ACT_ACCUM : (pick < 85) ? rsh_pkg::ACT_READ :
					(pick < 95) ? rsh_pkg::ACT_CLEAR : ACT_SPARE;
				sel = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, nb - 1));
				pw = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 9)) :
					32'($urandom);
				send_item(act, pick_coord(clamp_side(side_reg[0])),
					pick_coord(clamp_side(side_reg[1])), pick_coord(clamp_side(side_reg[2])),
					pw, sel);
				if (i == 50 && ph == 5) drain_results();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < 3; i++) side_reg[i] = rsh_pkg::SIDE_RST;
		for (int i = 0; i < 256; i++) begin
			hist_sum[i] = '0;
			hist_cnt[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_full_grid();
		test_directed_small_grid();
		test_random_phases();
		drain_results();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> radial_spectrum_histogram.f
+incdir+hdl
hdl/rsh_pkg.sv
hdl/radial_spectrum_histogram.sv
tb/tb.sv
